FILE: rtl/decimal_id_list_parser_defines.svh
// ----------------------------------------------------------------------------
// decimal id list parser assertion macros
// shared assertion forms, clocked on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef DECIMAL_ID_LIST_PARSER_DEFINES_SVH
`define DECIMAL_ID_LIST_PARSER_DEFINES_SVH

// condition holds at every edge out of reset
`define DILP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds at the same edge as the antecedent
`define DILP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds at the edge after the antecedent
`define DILP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/dilp_pkg.sv
// ----------------------------------------------------------------------------
// decimal id list parser package
// parse modes, status codes, character constants and sizing
// ----------------------------------------------------------------------------
`default_nettype none

package dilp_pkg;

  // default id width
  localparam int ID_BITS_DEFAULT = 24;

  // register widths and register indexes
  localparam int VOCAB_W    = 25;
  localparam int CAP_W      = 16;
  localparam int CFG_DATA_W = 25;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] REG_VOCAB_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ID_CAPACITY = 1'b1;

  // register reset values
  localparam logic [VOCAB_W-1:0] VOCAB_RESET = 25'h100_0000;
  localparam logic [CAP_W-1:0]   CAP_RESET   = 16'hFFFF;

  // result queue sizing
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCOUNT_W = 3;

  // character classes
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam int         RADIX      = 10;

  // result kinds
  localparam logic KIND_ID     = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    MODE_BETWEEN = 2'd0,
    MODE_TOKEN   = 2'd1,
    MODE_DONE    = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_CAPPED = 2'd1,
    STAT_ERROR  = 2'd2
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/decimal_id_list_parser.sv
// a word's results are written into the result queue at the edge that accepts it
// throughput: one input word per cycle while in_ready, one result word per cycle out while out_ready
// a word that ends a token and the list at once yields two results, both
// pushed together into a four-entry result queue that sets the input stall
// reset: synchronous rst clears parse state and queue, registers to defaults
// ----------------------------------------------------------------------------
// decimal id list parser
// splits a byte stream into whitespace separated decimal ids, checks each
// against the vocabulary size and the id capacity and ends each list with a status word
// ----------------------------------------------------------------------------
`default_nettype none

`include "decimal_id_list_parser_defines.svh"

module decimal_id_list_parser #(
  parameter int ID_BITS = dilp_pkg::ID_BITS_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration
  input  wire logic                           cfg_write,
  input  wire logic [dilp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dilp_pkg::CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [7:0]                     data_byte,
  input  wire logic                           has_byte,
  input  wire logic                           end_of_list,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                result_kind,
  output logic [ID_BITS-1:0]                  id_value,
  output logic [1:0]                          final_status,
  output logic [dilp_pkg::CAP_W-1:0]          id_count,
  output logic                                last_result
);

  // widths of the vocabulary limit, the scaled value and the compare
  localparam int VW = (ID_BITS + 1 > dilp_pkg::VOCAB_W) ? ID_BITS + 1 : dilp_pkg::VOCAB_W;
  localparam int MW = ID_BITS + 4;
  localparam int CW = (VW > MW) ? VW : MW;
  localparam logic [VW-1:0] VOCAB_LIM = VW'(1) << ID_BITS;

  typedef struct packed {
    logic                         kind;
    logic [ID_BITS-1:0]           id;
    dilp_pkg::status_t            stat;
    logic [dilp_pkg::CAP_W-1:0]   cnt;
    logic                         last;
  } result_t;

  // configuration registers
  logic [dilp_pkg::VOCAB_W-1:0] vocab_size;
  logic [dilp_pkg::CAP_W-1:0]   id_capacity;

  // parse state
  dilp_pkg::mode_t             mode, mode_next;
  logic [ID_BITS-1:0]          accum, accum_next;
  logic [dilp_pkg::CAP_W-1:0]  ids_done, ids_done_next;
  dilp_pkg::status_t           held, held_next;

  // result queue
  result_t                        queue [dilp_pkg::QDEPTH];
  logic [dilp_pkg::QPTR_W-1:0]    head, tail;
  logic [dilp_pkg::QCOUNT_W-1:0]  count;

  logic                        accept, pop;
  logic [VW-1:0]               vocab_eff;
  logic                        limit_hit, is_ws, is_digit;
  logic [3:0]                  digit_val;
  logic [MW-1:0]               accum_mul;
  logic                        first_over, mul_over;
  logic                        emit_id, emit_stat;
  logic [ID_BITS-1:0]          id_out;
  dilp_pkg::status_t           stat_out;
  logic [dilp_pkg::CAP_W-1:0]  cnt_out;
  result_t                     id_entry, stat_entry, entry_a;
  logic                        push_a, push_b;

  assign accept = in_valid && in_ready;
  assign pop    = out_valid && out_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      vocab_size  <= dilp_pkg::VOCAB_RESET;
      id_capacity <= dilp_pkg::CAP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dilp_pkg::REG_VOCAB_SIZE:  vocab_size  <= cfg_data[dilp_pkg::VOCAB_W-1:0];
        dilp_pkg::REG_ID_CAPACITY: id_capacity <= cfg_data[dilp_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // effective limit and byte classes
  assign vocab_eff = (VW'(vocab_size) > VOCAB_LIM) ? VOCAB_LIM : VW'(vocab_size);
  assign limit_hit = (mode != dilp_pkg::MODE_DONE) &&
                     ((vocab_eff == '0) || (id_capacity == '0));
  assign is_ws     = data_byte <= dilp_pkg::CHAR_SPACE;
  assign is_digit  = (data_byte >= dilp_pkg::CHAR_ZERO) && (data_byte <= dilp_pkg::CHAR_NINE);
  assign digit_val = data_byte[3:0];

  // value times ten plus the new digit
  assign accum_mul  = (MW'(accum) << 3) + (MW'(accum) << 1) + MW'(digit_val);
  assign first_over = CW'(digit_val) >= CW'(vocab_eff);
  assign mul_over   = CW'(accum_mul) >= CW'(vocab_eff);

  // next parse state and the results of the word
  always_comb begin
    mode_next     = mode;
    accum_next    = accum;
    ids_done_next = ids_done;
    held_next     = held;
    emit_id       = 1'b0;
    emit_stat     = 1'b0;
    id_out        = accum;
    stat_out      = dilp_pkg::STAT_OK;
    cnt_out       = ids_done;
    if (accept) begin
      if (limit_hit) begin
        mode_next = dilp_pkg::MODE_DONE;
        held_next = dilp_pkg::STAT_ERROR;
      end
      if (has_byte && (mode_next != dilp_pkg::MODE_DONE)) begin
        if (mode_next == dilp_pkg::MODE_BETWEEN) begin
          if (!is_ws) begin
            priority if (ids_done >= id_capacity) begin
              mode_next = dilp_pkg::MODE_DONE;
              held_next = dilp_pkg::STAT_CAPPED;
            end else if (is_digit && !first_over) begin
              accum_next = ID_BITS'(digit_val);
              mode_next  = dilp_pkg::MODE_TOKEN;
            end else begin
              mode_next = dilp_pkg::MODE_DONE;
              held_next = dilp_pkg::STAT_ERROR;
            end
          end
        end else begin
          priority if (is_ws) begin
            emit_id       = 1'b1;
            id_out        = accum;
            ids_done_next = ids_done + 1'b1;
            accum_next    = '0;
            mode_next     = dilp_pkg::MODE_BETWEEN;
          end else if (is_digit && !mul_over) begin
            accum_next = accum_mul[ID_BITS-1:0];
          end else begin
            mode_next = dilp_pkg::MODE_DONE;
            held_next = dilp_pkg::STAT_ERROR;
          end
        end
      end
      // end of list closes an open token and reports the status
      if (end_of_list) begin
        if (mode_next == dilp_pkg::MODE_TOKEN) begin
          emit_id       = 1'b1;
          id_out        = accum_next;
          ids_done_next = ids_done_next + 1'b1;
        end
        emit_stat = 1'b1;
        if (mode_next == dilp_pkg::MODE_DONE) begin
          stat_out = held_next;
          cnt_out  = (held_next == dilp_pkg::STAT_CAPPED) ? id_capacity : ids_done_next;
        end else begin
          stat_out = dilp_pkg::STAT_OK;
          cnt_out  = ids_done_next;
        end
        mode_next     = dilp_pkg::MODE_BETWEEN;
        accum_next    = '0;
        ids_done_next = '0;
        held_next     = dilp_pkg::STAT_OK;
      end
    end
  end

  // result words for the queue
  always_comb begin
    id_entry        = '0;
    id_entry.kind   = dilp_pkg::KIND_ID;
    id_entry.id     = id_out;
    id_entry.stat   = dilp_pkg::STAT_OK;
    stat_entry      = '0;
    stat_entry.kind = dilp_pkg::KIND_STATUS;
    stat_entry.stat = stat_out;
    stat_entry.cnt  = cnt_out;
    stat_entry.last = 1'b1;
    entry_a         = emit_id ? id_entry : stat_entry;
    push_a          = emit_id || emit_stat;
    push_b          = emit_id && emit_stat;
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= dilp_pkg::MODE_BETWEEN;
      accum    <= '0;
      ids_done <= '0;
      held     <= dilp_pkg::STAT_OK;
    end else begin
      mode     <= mode_next;
      accum    <= accum_next;
      ids_done <= ids_done_next;
      held     <= held_next;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (push_a) begin
      queue[tail] <= entry_a;
    end
    if (push_b) begin
      queue[tail + 1'b1] <= stat_entry;
    end
  end

  // result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (pop) begin
        head <= head + 1'b1;
      end
      tail  <= tail + dilp_pkg::QPTR_W'(push_a) + dilp_pkg::QPTR_W'(push_b);
      count <= count + dilp_pkg::QCOUNT_W'(push_a) + dilp_pkg::QCOUNT_W'(push_b)
               - dilp_pkg::QCOUNT_W'(pop);
    end
  end

  // handshake and result ports
  assign in_ready     = count <= dilp_pkg::QCOUNT_W'(dilp_pkg::QDEPTH - 2);
  assign out_valid    = count != '0;
  assign result_kind  = queue[head].kind;
  assign id_value     = queue[head].id;
  assign final_status = queue[head].stat;
  assign id_count     = queue[head].cnt;
  assign last_result  = queue[head].last;

  // checks
  `DILP_ASSERT_ALWAYS(a_queue_bound, count <= dilp_pkg::QCOUNT_W'(dilp_pkg::QDEPTH), "result queue overflow")
  `DILP_ASSERT_NOW(a_done_held, mode == dilp_pkg::MODE_DONE, held != dilp_pkg::STAT_OK, "finished early with ok status")
  `DILP_ASSERT_NEXT(a_end_clears, accept && end_of_list, (mode == dilp_pkg::MODE_BETWEEN) && (ids_done == '0) && (held == dilp_pkg::STAT_OK), "state not cleared after end of list")
  `DILP_ASSERT_NOW(a_last_is_status, out_valid && last_result, result_kind == dilp_pkg::KIND_STATUS, "last word is not a status")

endmodule

`default_nettype wire
